[rtl/tsu_pkg.sv]
package tsu_pkg;

    localparam int unsigned TIMER_WIDTH_DEF = 8;

    localparam logic [7:0]  BAUD_DIV_RESET = 8'd62;
    localparam logic [3:0]  TX_FRAME_BITS  = 4'd10;
    localparam logic [3:0]  RX_SAMPLES     = 4'd9;
    localparam logic [15:0] TX_PAD         = 16'hFF00;
    localparam logic [15:0] TX_FILL        = 16'h8000;

    typedef struct packed {
        logic       rx_line;
        logic       tx_load;
        logic [7:0] tx_data;
        logic       rx_take;
    } t_in_word;

    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       load_refused;
        logic       rx_ready;
        logic       rx_active;
        logic [7:0] rx_data;
    } t_out_word;

    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       load_refused;
    } t_tx_status;

    typedef struct packed {
        logic       rx_ready;
        logic       rx_active;
        logic [7:0] rx_data;
    } t_rx_status;

endpackage

[rtl/tsu_timer_tx.sv]
module tsu_timer_tx #(
    parameter int unsigned TIMER_WIDTH = tsu_pkg::TIMER_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_baud_div,
    input  logic                   i_tx_load,
    input  logic [7:0]             i_tx_data,
    output logic [TIMER_WIDTH-1:0] o_tick_count,
    output tsu_pkg::t_tx_status    o_status
);
    import tsu_pkg::*;

    logic [TIMER_WIDTH-1:0] r_tick, n_tick;
    logic [15:0]            r_shift, n_shift;
    logic [3:0]             r_bits, n_bits;
    logic                   r_level, n_level;
    logic [TIMER_WIDTH-1:0] baud_ext;
    logic                   wrap;
    logic                   refused;

    assign baud_ext = TIMER_WIDTH'(i_baud_div);
    assign wrap     = (r_tick >= baud_ext);

    always_comb begin
        n_tick  = r_tick;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_level = r_level;
        refused = 1'b0;
        if (wrap) begin
            n_level = r_shift[0];
            n_shift = (r_shift >> 1) | TX_FILL;
            if (r_bits != 4'd0) begin
                n_bits = r_bits - 4'd1;
            end
            n_tick = '0;
        end else begin
            n_tick = r_tick + TIMER_WIDTH'(1);
        end
        if (i_tx_load) begin
            if (n_bits == 4'd0) begin
                // Start bit in the low position, stop and idle bits above the data.
                n_shift = {TX_PAD[15:9], i_tx_data, 1'b0};
                n_bits  = TX_FRAME_BITS;
            end else begin
                refused = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_shift <= 16'hFFFF;
            r_bits  <= 4'd0;
            r_level <= 1'b1;
        end else if (i_step) begin
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_level <= n_level;
        end
    end

    assign o_tick_count          = r_tick;
    assign o_status.tx_line      = n_level;
    assign o_status.tx_busy      = (n_bits != 4'd0);
    assign o_status.load_refused = refused;

endmodule

[rtl/tsu_rx.sv]
module tsu_rx #(
    parameter int unsigned TIMER_WIDTH = tsu_pkg::TIMER_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_baud_div,
    input  logic [TIMER_WIDTH-1:0] i_tick_count,
    input  logic                   i_rx_line,
    input  logic                   i_rx_take,
    output tsu_pkg::t_rx_status    o_status
);
    import tsu_pkg::*;

    logic [7:0]             r_shift, n_shift;
    logic [3:0]             r_bits, n_bits;
    logic [TIMER_WIDTH-1:0] r_point, n_point;
    logic                   r_prev;
    logic                   r_active, n_active;
    logic [TIMER_WIDTH-1:0] half;
    logic                   ready;

    assign half = TIMER_WIDTH'(i_baud_div >> 1);

    always_comb begin
        n_shift  = r_shift;
        n_bits   = r_bits;
        n_point  = r_point;
        n_active = r_active;
        if (!r_active && r_prev && !i_rx_line) begin
            n_bits   = RX_SAMPLES;
            n_shift  = 8'd0;
            n_point  = (i_tick_count < half) ? i_tick_count + half : i_tick_count - half;
            n_active = 1'b1;
        end else if (r_active && (i_tick_count == r_point)) begin
            // Sample enters at the top and moves down, so the first data bit ends lowest.
            n_shift = {i_rx_line | r_shift[7], r_shift[6:0]};
            n_bits  = r_bits - 4'd1;
            if (n_bits == 4'd0) begin
                n_active = 1'b0;
            end else begin
                n_shift = n_shift >> 1;
            end
        end
        if (i_rx_take && !n_active && (n_bits == 4'd0)) begin
            n_bits = RX_SAMPLES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 8'd0;
            r_bits   <= RX_SAMPLES;
            r_point  <= '0;
            r_prev   <= 1'b1;
            r_active <= 1'b0;
        end else if (i_step) begin
            r_shift  <= n_shift;
            r_bits   <= n_bits;
            r_point  <= n_point;
            r_prev   <= i_rx_line;
            r_active <= n_active;
        end
    end

    assign ready              = !n_active && (n_bits == 4'd0);
    assign o_status.rx_ready  = ready;
    assign o_status.rx_active = n_active;
    assign o_status.rx_data   = ready ? n_shift : 8'd0;

endmodule

[rtl/timer_tick_soft_uart_unit.sv]
// An accepted tick word passes the input register, then the result register, where the
// timer, transmitter and receiver update. Throughput: one tick word per clock unless the
// output stalls; the result register frees as it is read.
// Reset (synchronous, i_rst_n low): timer at zero, line idle high, receiver armed,
// divider back to 62, both word registers empty.
module timer_tick_soft_uart_unit #(
    parameter int unsigned TIMER_WIDTH = tsu_pkg::TIMER_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tsu_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tsu_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);
    import tsu_pkg::*;

    t_in_word               r_in;
    logic                   r_in_vld;
    t_out_word              r_out, n_out;
    logic                   r_out_vld;
    logic [7:0]             r_baud;
    logic                   step;
    logic [TIMER_WIDTH-1:0] tick_count;
    t_tx_status             tx_status;
    t_rx_status             rx_status;

    assign step        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !step;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baud <= BAUD_DIV_RESET;
        end else if (i_cfg_valid) begin
            r_baud <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    tsu_timer_tx #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_timer_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_baud_div   (r_baud),
        .i_tx_load    (r_in.tx_load),
        .i_tx_data    (r_in.tx_data),
        .o_tick_count (tick_count),
        .o_status     (tx_status)
    );

    tsu_rx #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_baud_div   (r_baud),
        .i_tick_count (tick_count),
        .i_rx_line    (r_in.rx_line),
        .i_rx_take    (r_in.rx_take),
        .o_status     (rx_status)
    );

    always_comb begin
        n_out.tx_line      = tx_status.tx_line;
        n_out.tx_busy      = tx_status.tx_busy;
        n_out.load_refused = tx_status.load_refused;
        n_out.rx_ready     = rx_status.rx_ready;
        n_out.rx_active    = rx_status.rx_active;
        n_out.rx_data      = rx_status.rx_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

[bench/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tsu_pkg::*;

    localparam int IDLE_PCT      = 14;
    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 6;

    class uart_tick_scoreboard;
        bit [7:0]  divider;
        bit [7:0]  tick_count;
        bit [15:0] tx_shift;
        bit [3:0]  tx_bits_left;
        bit        tx_level;
        bit [7:0]  rx_shift;
        bit [3:0]  rx_bits_left;
        bit [7:0]  sample_point;
        bit        prev_rx_line;
        bit        rx_busy;
        bit        was_ready;
        t_out_word expected_words[$];
        int        errors;
        int        ticks;
        int        bytes_received;
        int        loads_taken;
        int        loads_refused;

        function new();
            divider      = BAUD_DIV_RESET;
            tick_count   = '0;
            tx_shift     = 16'hFFFF;
            tx_bits_left = '0;
            tx_level     = 1'b1;
            rx_shift     = '0;
            rx_bits_left = RX_SAMPLES;
            sample_point = '0;
            prev_rx_line = 1'b1;
            rx_busy      = 1'b0;
            was_ready    = 1'b0;
        endfunction

        function void set_divider(input bit [7:0] value);
            divider = value;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_tick(input t_in_word w);
            bit        started;
            bit        refused;
            bit        ready;
            bit [7:0]  half;
            t_out_word e;
            started = 1'b0;
            refused = 1'b0;
            ticks++;

            if (!rx_busy && prev_rx_line && !w.rx_line) begin
                half         = divider >> 1;
                rx_bits_left = RX_SAMPLES;
                rx_shift     = '0;
                sample_point = (tick_count < half) ? tick_count + half : tick_count - half;
                rx_busy      = 1'b1;
                started      = 1'b1;
            end

            // The frame's own start tick is never sampled, even on the sample point.
            if (rx_busy && !started && tick_count == sample_point) begin
                if (w.rx_line)
                    rx_shift[7] = 1'b1;
                rx_bits_left = rx_bits_left - 4'd1;
                if (rx_bits_left == 0)
                    rx_busy = 1'b0;
                else
                    rx_shift = rx_shift >> 1;
            end

            if (tick_count >= divider) begin
                tx_level = tx_shift[0];
                tx_shift = (tx_shift >> 1) | TX_FILL;
                if (tx_bits_left != 0)
                    tx_bits_left--;
                tick_count = '0;
            end else begin
                tick_count++;
            end

            if (w.tx_load) begin
                if (tx_bits_left == 0) begin
                    tx_shift     = ({8'h00, w.tx_data} + TX_PAD) << 1;
                    tx_bits_left = TX_FRAME_BITS;
                    loads_taken++;
                end else begin
                    refused = 1'b1;
                    loads_refused++;
                end
            end

            if (w.rx_take && !rx_busy && rx_bits_left == 0)
                rx_bits_left = RX_SAMPLES;

            prev_rx_line = w.rx_line;

            ready = !rx_busy && rx_bits_left == 0;
            if (ready && !was_ready)
                bytes_received++;
            was_ready = ready;

            e.tx_line      = tx_level;
            e.tx_busy      = (tx_bits_left != 0);
            e.load_refused = refused;
            e.rx_ready     = ready;
            e.rx_active    = rx_busy;
            e.rx_data      = ready ? rx_shift : 8'h00;
            expected_words.push_back(e);
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got) begin
                $error("Field %s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input t_out_word got);
            t_out_word e;
            if (expected_words.size() == 0) begin
                $error("Result word 0x%0h arrived with nothing expected", got);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            compare_field("tx_line", e.tx_line, got.tx_line);
            compare_field("tx_busy", e.tx_busy, got.tx_busy);
            compare_field("load_refused", e.load_refused, got.load_refused);
            compare_field("rx_ready", e.rx_ready, got.rx_ready);
            compare_field("rx_active", e.rx_active, got.rx_active);
            compare_field("rx_data", e.rx_data, got.rx_data);
        endfunction
    endclass

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_word   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_word  out_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    uart_tick_scoreboard sb = new();

    bit tx_idling = 1'b1;
    bit rx_idling = 1'b1;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int divider_writes = 0;

    timer_tick_soft_uart_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // The receiver's long hold-off is counted here, so the sender keeps offering words.
    always @(negedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= rx_idling && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_word);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_tick(input t_in_word w);
        @(negedge clk);
        while (tx_idling && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        sb.note_tick(w);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_divider(input bit [7:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_divider(value);
        divider_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Feeds the receive line with 8N1 frames at the current bit period, give or take one tick,
    // mixed with glitches and broken frames, while loads and takes arrive at random.
    task automatic run_phase(input bit [7:0] div, input int n_items, input int noise_pct,
                             input int hold_at, input bit calm);
        bit       line_levels[$];
        int       period;
        int       bit_len;
        bit [7:0] payload;
        bit       level;
        bit       frame_bits[10];
        t_in_word w;
        write_divider(div);
        period    = int'(div) + 1;
        tx_idling = !calm;
        rx_idling = !calm;
        for (int i = 0; i < n_items; i++) begin
            if (i == hold_at) begin
                hold_requests++;
                tx_idling = 1'b0;
            end
            if (hold_at >= 0 && i == hold_at + 300)
                tx_idling = !calm;
            if (line_levels.size() == 0) begin
                if ($urandom_range(0, 99) < noise_pct) begin
                    repeat ($urandom_range(1, 6)) begin
                        level = $urandom_range(0, 1);
                        repeat ($urandom_range(1, period)) line_levels.push_back(level);
                    end
                end else begin
                    payload = $urandom_range(0, 255);
                    bit_len = period;
                    if (period > 4)
                        bit_len = period + $urandom_range(0, 2) - 1;
                    frame_bits[0] = 1'b0;
                    for (int b = 0; b < 8; b++)
                        frame_bits[b + 1] = payload[b];
                    frame_bits[9] = ($urandom_range(0, 9) != 0);
                    repeat ($urandom_range(0, 2 * period)) line_levels.push_back(1'b1);
                    foreach (frame_bits[b])
                        repeat (bit_len) line_levels.push_back(frame_bits[b]);
                end
            end
            w.rx_line = line_levels.pop_front();
            w.tx_load = ($urandom_range(0, 99) < 6);
            w.tx_data = $urandom_range(0, 255);
            w.rx_take = ($urandom_range(0, 99) < 12);
            send_tick(w);
        end
        @(negedge clk);
        in_valid  <= 1'b0;
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    initial begin
        t_in_word directed[$];

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset divider: a load of 0xFF, a refused load of 0x00, a take with nothing ready,
        // and a start edge followed by a glitch back to idle.
        directed.push_back('{rx_line: 1'b1, tx_load: 1'b0, tx_data: 8'h00, rx_take: 1'b0});
        directed.push_back('{rx_line: 1'b1, tx_load: 1'b1, tx_data: 8'hFF, rx_take: 1'b1});
        directed.push_back('{rx_line: 1'b1, tx_load: 1'b1, tx_data: 8'h00, rx_take: 1'b0});
        directed.push_back('{rx_line: 1'b0, tx_load: 1'b0, tx_data: 8'hAA, rx_take: 1'b0});
        directed.push_back('{rx_line: 1'b0, tx_load: 1'b1, tx_data: 8'h55, rx_take: 1'b1});
        directed.push_back('{rx_line: 1'b1, tx_load: 1'b0, tx_data: 8'hFF, rx_take: 1'b0});
        directed.push_back('{rx_line: 1'b0, tx_load: 1'b1, tx_data: 8'h01, rx_take: 1'b0});
        directed.push_back('{rx_line: 1'b1, tx_load: 1'b0, tx_data: 8'h80, rx_take: 1'b1});
        foreach (directed[k])
            send_tick(directed[k]);
        @(negedge clk);
        in_valid <= 1'b0;

        run_phase(8'd2,   300, 10, -1,  1'b0);
        run_phase(8'd3,   300, 10, 100, 1'b0);
        run_phase(8'd5,   300, 10, -1,  1'b1);
        run_phase(8'd7,   250, 15, -1,  1'b0);
        run_phase(8'd1,   100, 10, -1,  1'b0);
        run_phase(8'd0,    60, 10, -1,  1'b0);
        run_phase(8'd255, 250, 5,  -1,  1'b0);
        // The counter is now well above the new top, so the timer wraps at once.
        run_phase(8'd2,   150, 10, -1,  1'b0);
        run_phase(8'd4,   230, 20, -1,  1'b0);

        wait_drained();

        $display("Ran %0d ticks over %0d divider settings: %0d bytes received,",
                 sb.ticks, divider_writes + 1, sb.bytes_received);
        $display("%0d loads sent and %0d refused while the transmitter was busy.",
                 sb.loads_taken, sb.loads_refused);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
